@@ rtl/cef_pkg.sv @@
// Shared types and command codes of the coalescing event FIFO.
`timescale 1ns / 1ps

package cef_pkg;

    // Command codes carried on s_tuser.
    typedef enum logic [1:0] {
        CMD_SUBMIT  = 2'd0,
        CMD_POP     = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_CONSUME = 2'd3
    } cmd_t;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned FILL_W  = 7;
    localparam int unsigned DROP_W  = 32;

    // One stored event, param_id in the lowest bits.
    typedef struct packed {
        logic [31:0] payload;
        logic [5:0]  other_flags;
        logic        runtime_temp;
        logic        tgt_flag;
        logic [7:0]  slot;
        logic [7:0]  track;
        logic [7:0]  scope;
        logic [15:0] param_id;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // One result item, ok in the lowest bit, zero padded to whole bytes.
    typedef struct packed {
        logic [6:0]        pad;
        logic [DROP_W-1:0] dropped_total;
        logic [FILL_W-1:0] fill_level;
        entry_t            entry;
        logic              merged;
        logic              ok;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

@@ rtl/cef_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cef_ram #(
    parameter int unsigned WIDTH = 80,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

@@ rtl/coalescing_event_fifo.sv @@
// Top level of the coalescing event FIFO: sequencer, pointers and result register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tuser: cmd; s_tdata: event fields
// m_       out        m_tvalid / m_tready  m_tdata: status, entry, fill, drops
//
// Each command passes through EXEC, RDWAIT for a non-empty pop, peek or consume,
// and RESP into the output register. A submit into a full queue that may
// coalesce scans the entries through the single RAM read port and one key
// comparator. Only one item is in flight; s_tready is high in the idle state.
// A waiting result sits in the output register; the sequencer holds in its
// response state while m_tready stalls. aresetn (synchronous, active low)
// empties the queue and clears the drop count; no clearing pass is needed.

module coalescing_event_fifo #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // bits from 0 up: param_id[15:0], scope[23:16], track[31:24], slot[39:32],
    // tgt_flag[40], is_runtime_temp[41], other_flags[47:42], payload[79:48]
    input  logic [cef_pkg::ENTRY_W-1:0]   s_tdata,
    // bits from 0 up: cmd[1:0]
    input  logic [cef_pkg::CMD_W-1:0]     s_tuser,
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bits from 0 up: ok[0], merged[1], out_param_id[17:2], out_scope[25:18],
    // out_track[33:26], out_slot[41:34], out_tgt_flag[42],
    // out_runtime_temp[43], out_other_flags[49:44], out_payload[81:50],
    // fill_level[88:82], dropped_total[120:89], zero pad[127:121]
    output logic [cef_pkg::RESULT_W-1:0]  m_tdata
);

    // Index into the store, and pointer with one wrap bit (counts modulo 2*depth).
    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned PTR_W = IDX_W + 1;
    localparam logic [PTR_W:0]   PTR_MOD = (PTR_W + 1)'(2 * QUEUE_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_V = (PTR_W + 1)'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t                        state_reg;
    cef_pkg::cmd_t                 cmd_reg;
    cef_pkg::entry_t               ev_reg;
    logic [PTR_W-1:0]              wr_ptr_reg;
    logic [PTR_W-1:0]              rd_ptr_reg;
    logic [PTR_W-1:0]              issue_ptr_reg;
    logic [PTR_W-1:0]              chk_ptr_reg;
    logic                          rd_valid_reg;
    logic [cef_pkg::DROP_W-1:0]    drop_reg;
    logic                          res_ok_reg;
    logic                          res_merged_reg;
    cef_pkg::entry_t               res_entry_reg;
    logic                          m_tvalid_reg;
    cef_pkg::result_t              m_out_reg;

    logic [PTR_W:0]                depth;
    logic                          full;
    logic                          empty;
    logic                          hit;
    logic                          out_free;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [IDX_W-1:0]              ram_raddr;
    logic [cef_pkg::ENTRY_W-1:0]   ram_rdata;
    cef_pkg::entry_t               rd_entry;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W + 1)'(1);
        return (s == PTR_MOD) ? '0 : s[PTR_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] w;
        w = {1'b0, p};
        if (w >= DEPTH_V) begin
            w = w - DEPTH_V;
        end
        return w[IDX_W-1:0];
    endfunction

    // Occupancy from the two pointers, modulo 2*depth.
    always_comb begin
        if (wr_ptr_reg >= rd_ptr_reg) begin
            depth = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        end else begin
            depth = {1'b0, wr_ptr_reg} + PTR_MOD - {1'b0, rd_ptr_reg};
        end
    end

    assign full  = (depth >= DEPTH_V);
    assign empty = (depth == '0);

    // Shared key comparator: match key equal and the stored entry read from the RAM not temporary.
    assign rd_entry = cef_pkg::entry_t'(ram_rdata);
    assign hit = (rd_entry.param_id == ev_reg.param_id)
              && (rd_entry.scope == ev_reg.scope)
              && (rd_entry.track == ev_reg.track)
              && (rd_entry.slot == ev_reg.slot)
              && !rd_entry.runtime_temp;

    // Write on a plain submit or on the coalescing hit; read the head or the scan cursor.
    always_comb begin
        ram_we = 1'b0;
        if (state_reg == ST_EXEC && cmd_reg == cef_pkg::CMD_SUBMIT && !full) begin
            ram_we = 1'b1;
        end
        if (state_reg == ST_SCAN && rd_valid_reg && hit) begin
            ram_we = 1'b1;
        end
        ram_waddr = (state_reg == ST_SCAN) ? ptr_idx(chk_ptr_reg) : ptr_idx(wr_ptr_reg);
        ram_raddr = (state_reg == ST_SCAN) ? ptr_idx(issue_ptr_reg) : ptr_idx(rd_ptr_reg);
    end

    cef_ram #(
        .WIDTH (cef_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ev_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            drop_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Retire the result once taken; the response state reloads instead.
            if (m_tvalid_reg && m_tready && state_reg != ST_RESP) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= cef_pkg::cmd_t'(s_tuser);
                        ev_reg    <= cef_pkg::entry_t'(s_tdata);
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC: begin
                    res_ok_reg     <= (cmd_reg == cef_pkg::CMD_SUBMIT) && !full;
                    res_merged_reg <= 1'b0;
                    res_entry_reg  <= '0;
                    if (cmd_reg == cef_pkg::CMD_SUBMIT) begin
                        if (!full) begin
                            // Store at the tail.
                            wr_ptr_reg <= ptr_next(wr_ptr_reg);
                            state_reg  <= ST_RESP;
                        end else if (ev_reg.tgt_flag && !ev_reg.runtime_temp) begin
                            // Walk from the oldest entry.
                            issue_ptr_reg <= rd_ptr_reg;
                            rd_valid_reg  <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end else begin
                            drop_reg  <= drop_reg + 1'b1;
                            state_reg <= ST_RESP;
                        end
                    end else if (empty) begin
                        state_reg <= ST_RESP;
                    end else begin
                        // Head read issued this cycle.
                        state_reg <= ST_RDWAIT;
                    end
                end

                ST_RDWAIT: begin
                    res_ok_reg <= 1'b1;
                    if (cmd_reg != cef_pkg::CMD_CONSUME) begin
                        res_entry_reg <= rd_entry;
                    end
                    if (cmd_reg != cef_pkg::CMD_PEEK) begin
                        rd_ptr_reg <= ptr_next(rd_ptr_reg);
                    end
                    state_reg <= ST_RESP;
                end

                ST_SCAN: begin
                    if (rd_valid_reg && hit) begin
                        // Overwrite in place (write issued by the RAM control).
                        res_ok_reg     <= 1'b1;
                        res_merged_reg <= 1'b1;
                        rd_valid_reg   <= 1'b0;
                        state_reg      <= ST_RESP;
                    end else if (rd_valid_reg && ptr_next(chk_ptr_reg) == wr_ptr_reg) begin
                        // Newest entry checked without a match: drop.
                        drop_reg     <= drop_reg + 1'b1;
                        rd_valid_reg <= 1'b0;
                        state_reg    <= ST_RESP;
                    end else begin
                        rd_valid_reg <= (issue_ptr_reg != wr_ptr_reg);
                        chk_ptr_reg  <= issue_ptr_reg;
                        if (issue_ptr_reg != wr_ptr_reg) begin
                            issue_ptr_reg <= ptr_next(issue_ptr_reg);
                        end
                    end
                end

                ST_RESP: begin
                    if (out_free) begin
                        m_tvalid_reg            <= 1'b1;
                        m_out_reg.pad           <= '0;
                        m_out_reg.ok            <= res_ok_reg;
                        m_out_reg.merged        <= res_merged_reg;
                        m_out_reg.entry         <= res_entry_reg;
                        m_out_reg.fill_level    <= cef_pkg::FILL_W'(depth);
                        m_out_reg.dropped_total <= drop_reg;
                        state_reg               <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_out_reg;

    // Occupancy never exceeds the queue depth.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth <= DEPTH_V)
        else $error("queue occupancy above depth");

    // A coalesced submit always reports success.
    a_merged_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_out_reg.ok || !m_out_reg.merged))
        else $error("merged result without ok");

    // One item in flight: no accept in the cycle after an accept.
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    // The drop count only steps by one.
    a_drop_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && drop_reg != $past(drop_reg))
            |-> (drop_reg == $past(drop_reg) + 1'b1))
        else $error("drop count jumped");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the coalescing event FIFO: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module tb;
    import cef_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH) + 1;
    localparam int SETTLE_CYC  = QUEUE_DEPTH + 8;
    localparam int RANDOM_ITEMS = 640;
    localparam int LIMIT_NS    = 800_000;

    typedef struct {
        cmd_t   op;
        entry_t ev;
    } cmd_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ENTRY_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = CMD_SUBMIT;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;

    coalescing_event_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor
    entry_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr = '0;
    logic [PTR_W-1:0]   rd_ptr = '0;
    logic [31:0]        drops = '0;

    function automatic result_t fifo_response(cmd_t op, entry_t ev);
        result_t          r;
        logic [PTR_W-1:0] fill;
        logic [PTR_W-1:0] c;
        int               idx;
        logic             hit;
        r = '0;
        hit = 1'b0;
        fill = wr_ptr - rd_ptr;
        if (op == CMD_SUBMIT) begin
            if (fill < QUEUE_DEPTH) begin
                slots[wr_ptr % QUEUE_DEPTH] = ev;
                wr_ptr = wr_ptr + 1'b1;
                r.ok = 1'b1;
            end else begin
                // full: a set-target, non-temporary event replaces the oldest
                // non-temporary entry with the same id/scope/track/slot
                if (ev.tgt_flag && !ev.runtime_temp) begin
                    c = rd_ptr;
                    while (!hit && c != wr_ptr) begin
                        idx = c % QUEUE_DEPTH;
                        if (slots[idx].param_id == ev.param_id && slots[idx].scope == ev.scope
                                && slots[idx].track == ev.track && slots[idx].slot == ev.slot
                                && !slots[idx].runtime_temp) begin
                            slots[idx] = ev;
                            hit = 1'b1;
                        end else begin
                            c = c + 1'b1;
                        end
                    end
                end
                if (hit) begin
                    r.ok = 1'b1;
                    r.merged = 1'b1;
                end else begin
                    drops = drops + 1;
                end
            end
        end else if (fill != 0) begin
            r.ok = 1'b1;
            if (op != CMD_CONSUME) r.entry = slots[rd_ptr % QUEUE_DEPTH];
            if (op != CMD_PEEK) rd_ptr = rd_ptr + 1'b1;
        end
        r.fill_level = wr_ptr - rd_ptr;
        r.dropped_total = drops;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus
    cmd_item_t cmd_backlog [$];
    int        gen_depth = 0;
    entry_t    key_pool [8];
    int        pool_n;

    function automatic entry_t rand_event();
        entry_t e;
        e.param_id     = 16'($urandom);
        e.scope        = 8'($urandom);
        e.track        = 8'($urandom);
        e.slot         = 8'($urandom);
        e.tgt_flag     = 1'($urandom_range(0, 1));
        e.runtime_temp = 1'($urandom_range(0, 1));
        e.other_flags  = 6'($urandom);
        e.payload      = $urandom;
        return e;
    endfunction

    // Key from the pool with chosen flags and fresh content.
    function automatic entry_t pool_event(int i, logic st, logic tmp);
        entry_t e;
        e = key_pool[i];
        e.tgt_flag     = st;
        e.runtime_temp = tmp;
        e.other_flags  = 6'($urandom);
        e.payload      = $urandom;
        return e;
    endfunction

    // Track the fill level as the command stream will leave it.
    function automatic void queue_cmd(cmd_t op, entry_t ev);
        cmd_item_t it;
        it.op = op;
        it.ev = ev;
        cmd_backlog.push_back(it);
        if (op == CMD_SUBMIT) begin
            if (gen_depth < QUEUE_DEPTH) gen_depth++;
        end else if (op != CMD_PEEK && gen_depth > 0) begin
            gen_depth--;
        end
    endfunction

    function automatic cmd_t rand_read_op();
        case ($urandom_range(0, 2))
            0:       return CMD_POP;
            1:       return CMD_PEEK;
            default: return CMD_CONSUME;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver
    int burst_left = 0;
    int gap_left = 0;
    logic in_taken = 1'b0;

    always @(negedge aclk) begin : drive_input
        cmd_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (cmd_backlog.size() > 0) begin
                nxt = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt.ev;
                s_tuser <= nxt.op;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 5) == 0) begin
                    burst_left = 60;
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = $urandom_range(0, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    int ready_mode = 0;
    int ready_hold = 0;
    int ready_tick = 0;

    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(50, 300);
        end else begin
            ready_hold--;
        end
        ready_tick++;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (ready_tick % 8 == 0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // ---------------------------------------------------------------- monitor
    result_t pending_responses [$];
    int      mismatch_cnt = 0;

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (mismatch_cnt < 10)
                $display("mismatch %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge aclk) begin : watch_output
        result_t want;
        result_t got;
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_responses.push_back(fifo_response(cmd_t'(s_tuser), entry_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (pending_responses.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result %0h at %0t", m_tdata, $realtime);
                    mismatch_cnt++;
                end else begin
                    want = pending_responses.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("merged", want.merged, got.merged);
                    check_field("out_param_id", want.entry.param_id, got.entry.param_id);
                    check_field("out_scope", want.entry.scope, got.entry.scope);
                    check_field("out_track", want.entry.track, got.entry.track);
                    check_field("out_slot", want.entry.slot, got.entry.slot);
                    check_field("out_tgt_flag", want.entry.tgt_flag, got.entry.tgt_flag);
                    check_field("out_runtime_temp", want.entry.runtime_temp,
                                got.entry.runtime_temp);
                    check_field("out_other_flags", want.entry.other_flags, got.entry.other_flags);
                    check_field("out_payload", want.entry.payload, got.entry.payload);
                    check_field("fill_level", want.fill_level, got.fill_level);
                    check_field("dropped_total", want.dropped_total, got.dropped_total);
                end
            end
        end
    end

    // ---------------------------------------------------------------- reset, limit
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL coalescing_event_fifo");
        $finish;
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        entry_t ones;
        entry_t zeros;
        entry_t e;
        int n0;
        int k;
        int r;
        ones = '1;
        zeros = '0;

        // empty queue, field extremes, every command
        queue_cmd(CMD_POP, ones);
        queue_cmd(CMD_PEEK, ones);
        queue_cmd(CMD_CONSUME, ones);
        queue_cmd(CMD_SUBMIT, ones);
        queue_cmd(CMD_SUBMIT, zeros);
        queue_cmd(CMD_PEEK, zeros);
        queue_cmd(CMD_POP, zeros);
        queue_cmd(CMD_CONSUME, zeros);
        queue_cmd(CMD_POP, zeros);

        // full queue: key 0 has a temporary entry ahead of a plain one,
        // key 1 differs only in slot and is held only as temporary
        key_pool[0] = ones;
        key_pool[1] = ones;
        key_pool[1].slot = 8'hFE;
        for (int i = 2; i < 5; i++) key_pool[i] = rand_event();
        queue_cmd(CMD_SUBMIT, pool_event(0, 1'b1, 1'b1));
        queue_cmd(CMD_SUBMIT, pool_event(0, 1'b0, 1'b0));
        queue_cmd(CMD_SUBMIT, pool_event(1, 1'b1, 1'b1));
        while (gen_depth < QUEUE_DEPTH)
            queue_cmd(CMD_SUBMIT, pool_event($urandom_range(2, 4), 1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1))));
        queue_cmd(CMD_SUBMIT, pool_event(0, 1'b1, 1'b0));   // coalesce past temp entry
        queue_cmd(CMD_SUBMIT, pool_event(0, 1'b1, 1'b1));   // temporary: drop
        queue_cmd(CMD_SUBMIT, pool_event(0, 1'b0, 1'b0));   // not set-target: drop
        queue_cmd(CMD_SUBMIT, pool_event(1, 1'b1, 1'b0));   // only temp match: drop
        queue_cmd(CMD_SUBMIT, rand_event());
        queue_cmd(CMD_SUBMIT, pool_event(2, 1'b1, 1'b0));
        queue_cmd(CMD_PEEK, zeros);
        queue_cmd(CMD_POP, zeros);
        queue_cmd(CMD_SUBMIT, pool_event(0, 1'b1, 1'b0));   // room again: stored
        queue_cmd(CMD_SUBMIT, pool_event(3, 1'b0, 1'b0));   // full, no coalesce

        n0 = cmd_backlog.size();
        while (cmd_backlog.size() - n0 < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                // fill with a few repeating keys, then hammer the full queue
                pool_n = $urandom_range(2, 8);
                for (int i = 0; i < pool_n; i++) begin
                    key_pool[i] = rand_event();
                    if ($urandom_range(0, 3) == 0) key_pool[i].param_id = $urandom_range(0, 1)
                                                                       ? 16'hFFFF : 16'h0000;
                end
                while (gen_depth < QUEUE_DEPTH) begin
                    if ($urandom_range(0, 7) == 0)
                        queue_cmd(rand_read_op(), rand_event());
                    else
                        queue_cmd(CMD_SUBMIT, pool_event($urandom_range(0, pool_n - 1),
                                                         1'($urandom_range(0, 1)),
                                                         $urandom_range(0, 4) == 0));
                end
                k = $urandom_range(8, 30);
                repeat (k) begin
                    r = $urandom_range(0, 9);
                    e = pool_event($urandom_range(0, pool_n - 1), 1'b1, 1'b0);
                    if (r == 6) e.tgt_flag = 1'b0;
                    if (r == 7) e.runtime_temp = 1'b1;
                    if (r == 8) e = rand_event();
                    queue_cmd(r == 9 ? CMD_PEEK : CMD_SUBMIT, e);
                end
                repeat ($urandom_range(1, 40)) queue_cmd(rand_read_op(), rand_event());
            end else if (r < 8) begin
                repeat ($urandom_range(10, 40)) begin
                    e = rand_event();
                    queue_cmd(cmd_t'($urandom_range(0, 3)), e);
                end
            end else begin
                while (gen_depth > 0) queue_cmd(rand_read_op(), rand_event());
                repeat ($urandom_range(1, 3)) queue_cmd(rand_read_op(), rand_event());
            end
        end

        while (cmd_backlog.size() != 0 || s_tvalid || pending_responses.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_responses.size() == 0) begin
            $display("PASS coalescing_event_fifo");
        end else begin
            $display("FAIL coalescing_event_fifo");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/cef_pkg.sv
rtl/cef_ram.sv
rtl/coalescing_event_fifo.sv
bench/tb.sv
